// ----- sv/cfe_pkg.sv -----
// shared types and constants for the co2 sensor uart frame engine
// no dependencies; imported by every module of the block

package cfe_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int BODY_BYTES  = FRAME_BYTES - 2;
	localparam int IDX_W       = $clog2(FRAME_BYTES + 1);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	// request commands
	localparam logic [2:0] CMD_RX_BYTE  = 3'd0;
	localparam logic [2:0] CMD_READ     = 3'd1;
	localparam logic [2:0] CMD_ABC_ON   = 3'd2;
	localparam logic [2:0] CMD_ABC_OFF  = 3'd3;
	localparam logic [2:0] CMD_ZERO_CAL = 3'd4;
	localparam logic [2:0] CMD_SPAN_CAL = 3'd5;
	localparam logic [2:0] CMD_SET_RANGE = 3'd6;
	localparam logic [2:0] CMD_TICK     = 3'd7;

	// result kinds
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_CHECKED = 2'd1;
	localparam logic [1:0] KIND_REFUSED = 2'd2;

	// frame bytes and opcodes
	localparam logic [7:0] HDR_START   = 8'hFF;
	localparam logic [7:0] HDR_SENSOR  = 8'h01;
	localparam logic [7:0] OP_READ     = 8'h86;
	localparam logic [7:0] OP_ABC      = 8'h79;
	localparam logic [7:0] ABC_ON_BYTE = 8'hA0;
	localparam logic [7:0] OP_ZERO     = 8'h87;
	localparam logic [7:0] OP_SPAN     = 8'h88;
	localparam logic [7:0] OP_RANGE    = 8'h99;

	localparam logic [15:0] SPAN_MIN = 16'd1000;
	localparam logic [15:0] SPAN_MAX = 16'd5000;

	localparam logic [31:0] PREHEAT_RESET = 32'd180000;

	// one queued job: a whole frame, a checked reply or a refusal
	typedef struct packed {
		logic [1:0]                      kind;
		logic [BODY_BYTES-1:0][7:0]      body;   // frame bytes 2..8
		logic                            reply_ok;
		logic [15:0]                     ppm;
		logic                            co2_valid;
	} job_t;

endpackage

// ----- sv/co2_sensor_uart_frame_engine.sv -----
// top level of the co2 sensor uart frame engine
// depends on cfe_pkg, cfe_front, cfe_queue and cfe_back

// Host side of a nine-byte uart sensor protocol. Requests come in on the
// slave stream with the command in tuser; a request becomes nine transmit
// bytes (0xFF, 0x01, opcode, five value bytes, negated-sum checksum), a refused
// read or span request becomes one refused result, and received bytes are
// gathered into a nine-byte reply that yields one checked result with the ppm
// value for a good read. The front end takes one input item per clock as long
// as its four-entry job queue has room; the back end sends a frame as nine
// byte results and any other result as a single one, so a stream of frame
// requests is limited by the byte serializer. Ticks and mid-reply bytes produce
// no result and never use queue space. preheat_ticks is to be written by the user
// through cfg_we/cfg_wdata while the block is idle; the block does not enforce it.

module co2_sensor_uart_frame_engine
	import cfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: preheat_ticks
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], request_value[23:8]
	input  logic [2:0]  s_axis_tuser,   // command[2:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // tx_byte[7:0], reply_ok[8], co2_ppm[24:9],
	                                    // co2_valid[25], zero[31:26]
	output logic [1:0]  m_axis_tuser,   // result_kind[1:0]
	output logic        m_axis_tlast    // frame_last
);

	logic        in_fire;
	logic        push;
	job_t        push_job;
	job_t        head;
	logic        q_empty;
	logic        q_full;
	logic        pop;
	logic [25:0] out_data;

	// request accepted whenever the queue can take a job
	assign s_axis_tready = !q_full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	cfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_fire       (in_fire),
		.command       (s_axis_tuser),
		.rx_byte       (s_axis_tdata[7:0]),
		.request_value (s_axis_tdata[23:8]),
		.push          (push),
		.push_job      (push_job)
	);

	cfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	cfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast),
		.out_data  (out_data)
	);

	assign m_axis_tdata = {6'd0, out_data};

	// queue never takes a job it has no room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into full queue");

	// last flag only on transmit bytes
	a_last_is_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_TX))
		else $error("tlast on non-transmit result");

	// a ppm value is only reported on a good checked reply
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[25]) |->
			(m_axis_tdata[8] && m_axis_tuser == KIND_CHECKED))
		else $error("co2_valid without good checked reply");

	// nothing pops from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule

// ----- sv/cfe_front.sv -----
// front end: accepts request items, keeps warm-up and reply state, builds jobs
// depends on cfe_pkg

module cfe_front
	import cfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_fire,
	input  logic [2:0]  command,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] request_value,
	output logic        push,
	output job_t        push_job
);

	logic [31:0]      preheat_q;
	logic [31:0]      tick_count_q;
	logic             warm_q;
	logic             awaiting_q;
	logic             is_read_q;
	logic [7:0]       exp_op_q;
	logic [IDX_W-1:0] rx_idx_q;
	logic [7:0]       rx_sum_q;
	logic             hdr_good_q;
	logic [7:0]       ppm_hi_q;
	logic [7:0]       ppm_lo_q;

	logic             warm_now;
	logic             send_frame;
	logic             refuse;
	logic             reply_done;
	logic [BODY_BYTES-1:0][7:0] body;
	logic [7:0]       csum;
	logic             reply_ok;

	assign warm_now = warm_q || (tick_count_q > preheat_q);

	always_comb begin
		body       = '0;
		send_frame = 1'b0;
		refuse     = 1'b0;
		unique case (command)
			CMD_READ: begin
				body[0] = OP_READ;
				send_frame = warm_now;
				refuse = !warm_now;
			end
			CMD_ABC_ON: begin
				body[0] = OP_ABC;
				body[1] = ABC_ON_BYTE;
				send_frame = 1'b1;
			end
			CMD_ABC_OFF: begin
				body[0] = OP_ABC;
				send_frame = 1'b1;
			end
			CMD_ZERO_CAL: begin
				body[0] = OP_ZERO;
				send_frame = 1'b1;
			end
			CMD_SPAN_CAL: begin
				body[0] = OP_SPAN;
				body[1] = request_value[15:8];
				body[2] = request_value[7:0];
				refuse = (request_value < SPAN_MIN) || (request_value > SPAN_MAX);
				send_frame = !refuse;
			end
			CMD_SET_RANGE: begin
				body[0] = OP_RANGE;
				body[4] = request_value[15:8];
				body[5] = request_value[7:0];
				send_frame = 1'b1;
			end
			default: ;
		endcase
		// checksum is the negated sum of frame bytes 1 to 7
		csum = 8'(0 - (HDR_SENSOR + body[0] + body[1] + body[2] + body[3]
			+ body[4] + body[5]));
		body[BODY_BYTES-1] = csum;
	end

	assign reply_done = (command == CMD_RX_BYTE) && awaiting_q
		&& (rx_idx_q == IDX_W'(FRAME_BYTES - 1));
	assign reply_ok = hdr_good_q && (rx_byte == 8'(0 - rx_sum_q));

	always_comb begin
		push_job = '0;
		if (reply_done) begin
			push_job.kind      = KIND_CHECKED;
			push_job.reply_ok  = reply_ok;
			push_job.co2_valid = reply_ok && is_read_q;
			push_job.ppm       = (reply_ok && is_read_q) ? {ppm_hi_q, ppm_lo_q} : 16'd0;
		end else if (refuse) begin
			push_job.kind = KIND_REFUSED;
		end else begin
			push_job.kind = KIND_TX;
			push_job.body = body;
		end
	end

	assign push = in_fire && (reply_done || refuse || send_frame);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preheat_q    <= PREHEAT_RESET;
			tick_count_q <= '0;
			warm_q       <= 1'b0;
			awaiting_q   <= 1'b0;
			is_read_q    <= 1'b0;
			exp_op_q     <= '0;
			rx_idx_q     <= '0;
			rx_sum_q     <= '0;
			hdr_good_q   <= 1'b0;
			ppm_hi_q     <= '0;
			ppm_lo_q     <= '0;
		end else begin
			if (cfg_we) begin
				preheat_q <= cfg_wdata;
			end
			if (in_fire) begin
				if (command == CMD_TICK) begin
					if (tick_count_q != '1) begin
						tick_count_q <= tick_count_q + 32'd1;
					end
				end
				if (command == CMD_READ) begin
					warm_q <= warm_now;
				end
				if (send_frame) begin
					awaiting_q <= 1'b1;
					is_read_q  <= (command == CMD_READ);
					exp_op_q   <= body[0];
					rx_idx_q   <= '0;
					rx_sum_q   <= '0;
					hdr_good_q <= 1'b0;
					ppm_hi_q   <= '0;
					ppm_lo_q   <= '0;
				end else if (command == CMD_RX_BYTE && awaiting_q) begin
					if (reply_done) begin
						awaiting_q <= 1'b0;
						rx_idx_q   <= '0;
						rx_sum_q   <= '0;
					end else begin
						rx_idx_q <= rx_idx_q + IDX_W'(1);
						if (rx_idx_q == '0) begin
							hdr_good_q <= (rx_byte == HDR_START);
						end else begin
							rx_sum_q <= rx_sum_q + rx_byte;
							if (rx_idx_q == IDX_W'(1)) begin
								hdr_good_q <= hdr_good_q && (rx_byte == exp_op_q);
							end
							if (rx_idx_q == IDX_W'(2)) begin
								ppm_hi_q <= rx_byte;
							end
							if (rx_idx_q == IDX_W'(3)) begin
								ppm_lo_q <= rx_byte;
							end
						end
					end
				end
			end
		end
	end

endmodule

// ----- sv/cfe_queue.sv -----
// short job queue between front and back end
// depends on cfe_pkg

module cfe_queue
	import cfe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  job_t  push_job,
	input  logic  pop,
	output job_t  head,
	output logic  empty,
	output logic  full
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- sv/cfe_back.sv -----
// back end: serializes queued jobs into result items behind an output register
// depends on cfe_pkg

module cfe_back
	import cfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic        out_last,
	output logic [25:0] out_data
);

	job_t             job_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [1:0]       kind_q;
	logic             last_q;
	logic [25:0]      data_q;

	logic             out_free;
	logic [7:0]       cur_byte;
	logic [2:0]       body_sel;

	assign out_free = !valid_q || out_ready;
	assign pop      = out_free && !busy_q && !empty;
	assign body_sel = 3'(idx_q - IDX_W'(2));

	always_comb begin
		if (idx_q == IDX_W'(1)) begin
			cur_byte = HDR_SENSOR;
		end else begin
			cur_byte = job_q.body[body_sel];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (out_free) begin
			if (busy_q) begin
				kind_q <= KIND_TX;
				last_q <= (idx_q == IDX_W'(FRAME_BYTES - 1));
				data_q <= {18'd0, cur_byte};
			end else if (head.kind == KIND_TX) begin
				kind_q <= KIND_TX;
				last_q <= 1'b0;
				data_q <= {18'd0, HDR_START};
			end else begin
				kind_q <= head.kind;
				last_q <= 1'b0;
				data_q <= {head.co2_valid, head.ppm, head.reply_ok, 8'd0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (out_free) begin
			if (busy_q) begin
				valid_q <= 1'b1;
				if (idx_q == IDX_W'(FRAME_BYTES - 1)) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + IDX_W'(1);
			end else if (!empty) begin
				valid_q <= 1'b1;
				busy_q  <= (head.kind == KIND_TX);
				idx_q   <= IDX_W'(1);
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;
	assign out_data  = data_q;

endmodule
